// ----- rtl/core/boid_pkg.sv -----
// Shared types and codes for the BER object identifier decoder.
package boid_pkg;

   // Result kinds
   localparam logic [1:0] KIND_ARC  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_WRONG_TAG    = 3'd0;
   localparam logic [2:0] ERR_LEN_TOO_LONG = 3'd1;
   localparam logic [2:0] ERR_EMPTY        = 3'd2;
   localparam logic [2:0] ERR_EARLY_END    = 3'd3;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd4;

   // Number of result words one input word can cause
   localparam int unsigned MAX_RESULTS = 3;

   // One result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] arc_value;
      logic [4:0]  arc_index;
      logic [63:0] consumed_bytes;
      logic [2:0]  error_code;
      logic        last_of_run;
   } result_type;

endpackage

// ----- rtl/core/ber_oid_tlv_decoder.sv -----
// Top level of the BER object identifier TLV decoder.
//
// Bytes of a BER buffer enter on the req_ channel, one word per byte, with
// req_end_of_buffer marking the last byte. The tag must be 0x06; the length
// may be short form or long form with up to eight octets. The content is
// decoded into arcs, the first subidentifier yielding two arcs.
// Each byte gives zero to three words on the rsp_ channel: arcs, then one
// done word (with the bytes consumed) or one error word. rsp_last_of_run
// flags the final word caused by a byte.
// The first result word of an accepted byte appears in the cycle after it.
// A byte enters every cycle while each byte gives at most one word and the
// receiver does not stall; a byte giving more words holds the next byte back,
// as the single result register bank hands out one word per unstalled cycle.
// After done or error the decoder ignores bytes up to the end-of-buffer
// byte and then waits for a new tag. Reset (synchronous) clears the decode
// state and drops any pending result. While the receiver stalls, the current
// result word holds and req_stall rises once the bank cannot empty.
module ber_oid_tlv_decoder #(
   parameter int unsigned MAX_ARCS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_arc_value,
   output logic [4:0]  rsp_arc_index,
   output logic [63:0] rsp_consumed_bytes,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run
);
   import boid_pkg::*;

   logic                         accept;
   logic                         can_load;
   result_type [MAX_RESULTS-1:0] step_results;
   logic [1:0]                   step_count;
   result_type                   out_result;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   // Decode state and per-byte logic
   boid_step #(
      .MAX_ARCS (MAX_ARCS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .results       (step_results),
      .result_count  (step_count)
   );

   // Result words out, one per cycle while the receiver does not stall
   boid_rsp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .load_results (step_results),
      .load_count   (step_count),
      .out_stall    (rsp_stall),
      .out_valid    (rsp_valid),
      .out_result   (out_result),
      .can_load     (can_load)
   );

   assign rsp_kind           = out_result.kind;
   assign rsp_arc_value      = out_result.arc_value;
   assign rsp_arc_index      = out_result.arc_index;
   assign rsp_consumed_bytes = out_result.consumed_bytes;
   assign rsp_error_code     = out_result.error_code;
   assign rsp_last_of_run    = out_result.last_of_run;

endmodule

// ----- rtl/core/boid_step.sv -----
// Decoder state and the per-byte decode that produces up to three results.
module boid_step #(
   parameter int unsigned MAX_ARCS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  logic [7:0]                                  data_byte,
   input  logic                                        end_of_buffer,
   output boid_pkg::result_type [boid_pkg::MAX_RESULTS-1:0] results,
   output logic [1:0]                                  result_count
);
   import boid_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_ARCS + 1);
   localparam int unsigned EXT_W = (CNT_W > 5) ? CNT_W : 5;

   localparam logic [2:0] PH_TAG       = 3'd0;
   localparam logic [2:0] PH_LEN_FIRST = 3'd1;
   localparam logic [2:0] PH_LEN_MORE  = 3'd2;
   localparam logic [2:0] PH_CONTENT   = 3'd3;
   localparam logic [2:0] PH_DRAIN     = 3'd4;

   localparam logic [7:0] TAG_OID = 8'h06;

   logic [2:0]       phase_ff, phase_in;
   logic [3:0]       len_left_ff, len_left_in;
   logic [3:0]       len_count_ff, len_count_in;
   logic [63:0]      content_len_ff, content_len_in;
   logic [63:0]      content_left_ff, content_left_in;
   logic [31:0]      subid_ff, subid_in;
   logic [CNT_W-1:0] arc_count_ff, arc_count_in;
   logic             first_done_ff, first_done_in;

   // Per-byte decode: next state, arcs and an optional closing result
   always_comb begin
      logic [1:0]       arc_n;
      logic [31:0]      arc_val0, arc_val1;
      logic [CNT_W-1:0] arc_idx0, arc_idx1;
      logic             fin;
      logic [1:0]       fin_kind;
      logic [2:0]       fin_err;
      logic [63:0]      fin_total;
      logic [6:0]       oct_cnt;
      logic [63:0]      len_shift;
      logic [3:0]       len_left_dec;
      logic             active;
      logic             cont;
      logic [31:0]      subid_new;
      logic [CNT_W:0]   cnt_plus1;
      logic [64:0]      total_wide;
      logic [EXT_W-1:0] idx0_ext, idx1_ext;
      result_type       r_arc0, r_arc1, r_fin;

      phase_in        = phase_ff;
      len_left_in     = len_left_ff;
      len_count_in    = len_count_ff;
      content_len_in  = content_len_ff;
      content_left_in = content_left_ff;
      subid_in        = subid_ff;
      arc_count_in    = arc_count_ff;
      first_done_in   = first_done_ff;

      arc_n     = 2'd0;
      arc_val0  = '0;
      arc_val1  = '0;
      arc_idx0  = arc_count_ff;
      arc_idx1  = arc_count_ff + CNT_W'(1);
      fin       = 1'b0;
      fin_kind  = KIND_ERR;
      fin_err   = ERR_WRONG_TAG;
      fin_total = '0;

      oct_cnt      = data_byte[6:0];
      len_shift    = {content_len_ff[55:0], data_byte};
      len_left_dec = len_left_ff - 4'd1;
      active       = (arc_count_ff < CNT_W'(MAX_ARCS));
      cont         = data_byte[7];
      subid_new    = {subid_ff[24:0], data_byte[6:0]};
      cnt_plus1    = {1'b0, arc_count_ff} + (CNT_W + 1)'(1);
      total_wide   = {1'b0, content_len_ff} + 65'({len_count_ff} + 5'd1);

      case (phase_ff)
         PH_TAG: begin
            len_left_in     = '0;
            len_count_in    = '0;
            content_len_in  = '0;
            content_left_in = '0;
            subid_in        = '0;
            arc_count_in    = '0;
            first_done_in   = 1'b0;
            if (data_byte != TAG_OID) begin
               fin     = 1'b1;
               fin_err = ERR_WRONG_TAG;
            end else if (end_of_buffer) begin
               fin     = 1'b1;
               fin_err = ERR_EARLY_END;
            end else begin
               phase_in = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST: begin
            if (!data_byte[7]) begin
               // Short form length
               content_len_in  = 64'(data_byte);
               content_left_in = 64'(data_byte);
               len_count_in    = 4'd1;
               if (data_byte == 8'd0) begin
                  fin     = 1'b1;
                  fin_err = ERR_EMPTY;
               end else if (end_of_buffer) begin
                  fin     = 1'b1;
                  fin_err = ERR_EARLY_END;
               end else begin
                  phase_in = PH_CONTENT;
               end
            end else begin
               // Long form: the low seven bits count the length octets
               if (oct_cnt > 7'd8) begin
                  fin     = 1'b1;
                  fin_err = ERR_LEN_TOO_LONG;
               end else if (oct_cnt == 7'd0) begin
                  len_count_in = 4'd1;
                  fin          = 1'b1;
                  fin_err      = ERR_EMPTY;
               end else if (end_of_buffer) begin
                  fin     = 1'b1;
                  fin_err = ERR_EARLY_END;
               end else begin
                  len_left_in    = oct_cnt[3:0];
                  len_count_in   = oct_cnt[3:0] + 4'd1;
                  content_len_in = '0;
                  phase_in       = PH_LEN_MORE;
               end
            end
         end
         PH_LEN_MORE: begin
            content_len_in = len_shift;
            len_left_in    = len_left_dec;
            if (len_left_dec == 4'd0) begin
               content_left_in = len_shift;
               if (len_shift == 64'd0) begin
                  fin     = 1'b1;
                  fin_err = ERR_EMPTY;
               end else if (end_of_buffer) begin
                  fin     = 1'b1;
                  fin_err = ERR_EARLY_END;
               end else begin
                  phase_in = PH_CONTENT;
               end
            end else if (end_of_buffer) begin
               fin     = 1'b1;
               fin_err = ERR_EARLY_END;
            end
         end
         PH_CONTENT: begin
            // Gather the subidentifier and emit arcs when it terminates
            if (active) begin
               subid_in = subid_new;
               if (!cont) begin
                  subid_in = '0;
                  if (!first_done_ff) begin
                     first_done_in = 1'b1;
                     if (subid_new < 32'd40) begin
                        arc_val0 = 32'd0;
                        arc_val1 = subid_new;
                     end else if (subid_new < 32'd80) begin
                        arc_val0 = 32'd1;
                        arc_val1 = subid_new - 32'd40;
                     end else begin
                        arc_val0 = 32'd2;
                        arc_val1 = subid_new - 32'd80;
                     end
                     if (cnt_plus1 < (CNT_W + 1)'(MAX_ARCS)) begin
                        arc_n        = 2'd2;
                        arc_count_in = arc_count_ff + CNT_W'(2);
                     end else begin
                        arc_n        = 2'd1;
                        arc_count_in = arc_count_ff + CNT_W'(1);
                     end
                  end else begin
                     arc_val0     = subid_new;
                     arc_n        = 2'd1;
                     arc_count_in = arc_count_ff + CNT_W'(1);
                  end
               end
            end
            content_left_in = content_left_ff - 64'd1;
            if (content_left_ff == 64'd1) begin
               fin = 1'b1;
               if (active && cont) begin
                  fin_err = ERR_UNTERMINATED;
               end else begin
                  fin_kind  = KIND_DONE;
                  fin_total = total_wide[64] ? '1 : total_wide[63:0];
               end
            end else if (end_of_buffer) begin
               fin     = 1'b1;
               fin_err = ERR_EARLY_END;
            end
         end
         default: begin
            // Draining until the end of the buffer
            if (end_of_buffer) begin
               phase_in = PH_TAG;
            end
         end
      endcase

      if (fin) begin
         phase_in = end_of_buffer ? PH_TAG : PH_DRAIN;
      end

      // Assemble the result words: arcs first, then done or error
      idx0_ext = EXT_W'(arc_idx0);
      idx1_ext = EXT_W'(arc_idx1);

      r_arc0                = '0;
      r_arc0.kind           = KIND_ARC;
      r_arc0.arc_value      = arc_val0;
      r_arc0.arc_index      = idx0_ext[4:0];
      r_arc0.last_of_run    = (arc_n == 2'd1) && !fin;

      r_arc1                = '0;
      r_arc1.kind           = KIND_ARC;
      r_arc1.arc_value      = arc_val1;
      r_arc1.arc_index      = idx1_ext[4:0];
      r_arc1.last_of_run    = !fin;

      r_fin                 = '0;
      r_fin.kind            = fin_kind;
      r_fin.consumed_bytes  = (fin_kind == KIND_DONE) ? fin_total : 64'd0;
      r_fin.error_code      = (fin_kind == KIND_ERR) ? fin_err : ERR_WRONG_TAG;
      r_fin.last_of_run     = 1'b1;

      results[0]   = (arc_n != 2'd0) ? r_arc0 : r_fin;
      results[1]   = (arc_n == 2'd2) ? r_arc1 : r_fin;
      results[2]   = r_fin;
      result_count = arc_n + {1'b0, fin};
   end

   // State registers, updated on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         len_left_ff     <= '0;
         len_count_ff    <= '0;
         content_len_ff  <= '0;
         content_left_ff <= '0;
         subid_ff        <= '0;
         arc_count_ff    <= '0;
         first_done_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         len_left_ff     <= len_left_in;
         len_count_ff    <= len_count_in;
         content_len_ff  <= content_len_in;
         content_left_ff <= content_left_in;
         subid_ff        <= subid_in;
         arc_count_ff    <= arc_count_in;
         first_done_ff   <= first_done_in;
      end
   end

endmodule

// ----- rtl/core/boid_rsp_queue.sv -----
// Result register bank that holds the words of one byte and hands them out in order.
module boid_rsp_queue (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        load,
   input  boid_pkg::result_type [boid_pkg::MAX_RESULTS-1:0] load_results,
   input  logic [1:0]                                  load_count,
   input  logic                                        out_stall,
   output logic                                        out_valid,
   output boid_pkg::result_type                        out_result,
   output logic                                        can_load
);
   import boid_pkg::*;

   result_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [1:0]                   count_ff, count_in;
   logic                         pop;

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = slot_ff[0];
   assign pop        = out_valid && !out_stall;

   // A new byte may enter once the bank will be empty after this cycle
   assign can_load = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   // Load a fresh set of words, or shift the bank down by one on a pop
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (load) begin
         slot_in  = load_results;
         count_in = load_count;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/boid_checker.sv -----
// Port-level assertions for the decoder, bound to the top level.
module boid_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_arc_value,
   input logic [63:0] rsp_consumed_bytes,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last_of_run
);
   import boid_pkg::*;

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A stalled result word is held with its kind, arc value, byte count and error code.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_arc_value) && $stable(rsp_consumed_bytes)
         && $stable(rsp_error_code))
      else $error("stalled result word changed");

   // No new byte is taken while a result word sits stalled.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("byte accepted over a stalled result");

   // Done and error words always close the run of their byte and carry a zero arc value.
   a_closing_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ERR)
         |-> rsp_last_of_run && rsp_arc_value == 32'd0)
      else $error("closing word malformed");

   // Only the three defined kinds appear.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 2'd3)
      else $error("undefined result kind");

endmodule

bind ber_oid_tlv_decoder boid_checker u_boid_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_arc_value      (rsp_arc_value),
   .rsp_consumed_bytes (rsp_consumed_bytes),
   .rsp_error_code     (rsp_error_code),
   .rsp_last_of_run    (rsp_last_of_run)
);

// ----- test/ber_oid_tlv_decoder_test.sv -----
// Self-checking testbench for the BER object identifier TLV decoder.
module ber_oid_tlv_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import boid_pkg::*;

   localparam int unsigned ARC_LIMIT = 32;
   localparam int unsigned MAX_LEN_OCTETS = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned STIMULUS_WORDS = 275;
   localparam logic [7:0] TAG_OID = 8'h06;
   localparam logic [7:0] LONG_FORM = 8'h80;
   localparam logic [31:0] FIRST_ARC_SPAN = 32'd40;

   typedef enum logic [2:0] {
      PH_TAG, PH_LEN_FIRST, PH_LEN_MORE, PH_CONTENT, PH_DRAIN
   } oid_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eob;
   } req_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_arc_value;
   logic [4:0]  rsp_arc_index;
   logic [63:0] rsp_consumed_bytes;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_of_run;

   ber_oid_tlv_decoder #(.MAX_ARCS(ARC_LIMIT)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_arc_value      (rsp_arc_value),
      .rsp_arc_index      (rsp_arc_index),
      .rsp_consumed_bytes (rsp_consumed_bytes),
      .rsp_error_code     (rsp_error_code),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // Decoder state as the testbench believes it to be.
   oid_phase_type dec_phase = PH_TAG;
   logic [3:0]  octets_left = '0;
   logic [3:0]  octet_count = '0;
   logic [63:0] content_len = '0;
   logic [63:0] content_rem = '0;
   logic [31:0] subid_acc = '0;
   int unsigned arcs_out = 0;
   bit          first_done = 1'b0;

   result_type   step_words[$];
   result_type   expected_words[$];
   req_word_type byte_queue[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   bit          quiet = 1'b0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // Emits one arc word unless the identifier is already full.
   task automatic push_arc(input logic [31:0] value);
      result_type w;
      if (arcs_out < ARC_LIMIT) begin
         w = '0;
         w.kind = KIND_ARC;
         w.arc_value = value;
         w.arc_index = 5'(arcs_out);
         step_words.push_back(w);
         arcs_out++;
      end
   endtask

   task automatic close_with_error(input logic [2:0] code, input logic eob);
      result_type w;
      w = '0;
      w.kind = KIND_ERR;
      w.error_code = code;
      step_words.push_back(w);
      dec_phase = eob ? PH_TAG : PH_DRAIN;
   endtask

   // Works out the words that one accepted byte should produce.
   task automatic decode_byte(input logic [7:0] b, input logic eob);
      result_type  w;
      logic [64:0] total;
      logic [31:0] v;
      logic [31:0] a0;
      bit          active;
      bit          cont;
      step_words.delete();
      case (dec_phase)
         PH_TAG: begin
            octets_left = '0;
            octet_count = '0;
            content_len = '0;
            content_rem = '0;
            subid_acc = '0;
            arcs_out = 0;
            first_done = 1'b0;
            if (b != TAG_OID) close_with_error(ERR_WRONG_TAG, eob);
            else if (eob) close_with_error(ERR_EARLY_END, eob);
            else dec_phase = PH_LEN_FIRST;
         end
         PH_LEN_FIRST: begin
            if (!b[7]) begin
               content_len = 64'(b);
               content_rem = 64'(b);
               octet_count = 4'd1;
               if (b == 8'd0) close_with_error(ERR_EMPTY, eob);
               else if (eob) close_with_error(ERR_EARLY_END, eob);
               else dec_phase = PH_CONTENT;
            end else if (b[6:0] > MAX_LEN_OCTETS) begin
               close_with_error(ERR_LEN_TOO_LONG, eob);
            end else if (b[6:0] == 7'd0) begin
               // Indefinite form carries no length at all.
               octet_count = 4'd1;
               close_with_error(ERR_EMPTY, eob);
            end else if (eob) begin
               close_with_error(ERR_EARLY_END, eob);
            end else begin
               octets_left = 4'(b[6:0]);
               octet_count = 4'(b[6:0]) + 4'd1;
               content_len = '0;
               dec_phase = PH_LEN_MORE;
            end
         end
         PH_LEN_MORE: begin
            content_len = {content_len[55:0], b};
            octets_left = octets_left - 4'd1;
            if (octets_left == 4'd0) begin
               content_rem = content_len;
               if (content_len == 64'd0) close_with_error(ERR_EMPTY, eob);
               else if (eob) close_with_error(ERR_EARLY_END, eob);
               else dec_phase = PH_CONTENT;
            end else if (eob) begin
               close_with_error(ERR_EARLY_END, eob);
            end
         end
         PH_CONTENT: begin
            active = arcs_out < ARC_LIMIT;
            cont = b[7];
            if (active) begin
               subid_acc = {subid_acc[24:0], b[6:0]};
               if (!cont) begin
                  v = subid_acc;
                  // The first subidentifier splits into two arcs.
                  if (!first_done) begin
                     a0 = (v < FIRST_ARC_SPAN) ? 32'd0 :
                          (v < 2 * FIRST_ARC_SPAN) ? 32'd1 : 32'd2;
                     push_arc(a0);
                     push_arc(v - FIRST_ARC_SPAN * a0);
                     first_done = 1'b1;
                  end else begin
                     push_arc(v);
                  end
                  subid_acc = '0;
               end
            end
            content_rem = content_rem - 64'd1;
            if (content_rem == 64'd0) begin
               if (active && cont) begin
                  close_with_error(ERR_UNTERMINATED, eob);
               end else begin
                  total = {1'b0, content_len} + 65'(octet_count) + 65'd1;
                  w = '0;
                  w.kind = KIND_DONE;
                  w.consumed_bytes = total[64] ? '1 : total[63:0];
                  step_words.push_back(w);
                  dec_phase = eob ? PH_TAG : PH_DRAIN;
               end
            end else if (eob) begin
               close_with_error(ERR_EARLY_END, eob);
            end
         end
         default: begin
            if (eob) dec_phase = PH_TAG;
         end
      endcase
      if (step_words.size() > 0)
         step_words[step_words.size() - 1].last_of_run = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   // Mostly short pauses, now and then a long one, none in quiet stretches.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_byte(input logic [7:0] b, input logic eob);
      req_word_type w;
      w.data = b;
      w.eob = eob;
      byte_queue.push_back(w);
   endtask

   // One random buffer: mostly well-formed TLVs, some broken, some noise.
   task automatic queue_random_buffer();
      logic [7:0]  frame[$];
      logic [63:0] len_val;
      int unsigned n;
      int unsigned octs;
      int unsigned mode;
      int unsigned stop;
      int unsigned cont_pct;
      bit          huge;
      mode = $urandom_range(0, 99);
      if (mode < 10) begin
         repeat ($urandom_range(1, 6))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
         return;
      end
      if (mode < 14) begin
         // More length octets than allowed.
         frame.push_back(TAG_OID);
         frame.push_back(LONG_FORM | 8'($urandom_range(MAX_LEN_OCTETS + 1, 127)));
      end else begin
         // Capacity runs, long subidentifiers, or ordinary identifiers.
         n = (mode < 20) ? $urandom_range(33, 40) : $urandom_range(1, 10);
         cont_pct = (mode < 20) ? 10 : ((mode < 30) ? 85 : 25);
         huge = ($urandom_range(0, 19) == 0);
         frame.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                       : TAG_OID);
         if (!huge && $urandom_range(0, 1) == 1) begin
            frame.push_back(8'(n));
         end else begin
            octs = $urandom_range(1, MAX_LEN_OCTETS);
            len_val = huge ? {$urandom, $urandom} : 64'(n);
            frame.push_back(LONG_FORM | 8'(octs));
            for (int i = int'(octs) - 1; i >= 0; i--)
               frame.push_back(len_val[8 * i +: 8]);
         end
         for (int i = 0; i < int'(n); i++)
            frame.push_back({$urandom_range(0, 99) < cont_pct, 7'($urandom_range(0, 127))});
         if (mode >= 20 && $urandom_range(0, 9) != 0)
            frame[frame.size() - 1][7] = 1'b0;
      end
      stop = frame.size() - 1;
      if (huge || $urandom_range(0, 11) == 0)
         stop = $urandom_range(0, frame.size() - 2);
      else if ($urandom_range(0, 3) == 0)
         // Trailing bytes that the decoder must skip.
         repeat ($urandom_range(1, 3)) begin
            frame.push_back(8'($urandom_range(0, 255)));
            stop++;
         end
      for (int i = 0; i <= int'(stop); i++) add_byte(frame[i], i == int'(stop));
   endtask

   // Cycle count, quiet stretches and the overall time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 150 == 0) quiet <= ($urandom_range(0, 3) == 0);
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Driver: presents queued words and predicts each one as it is taken.
   always @(posedge clock) begin
      req_word_type w;
      bit           taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_stall === 1'b0;
         if (taken) decode_byte(req_data_byte, req_end_of_buffer);
         if (taken || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               w = byte_queue.pop_front();
               req_data_byte <= w.data;
               req_end_of_buffer <= w.eob;
               req_valid <= 1'b1;
               gap_left = idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure and word-by-word comparison.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            got.kind = rsp_kind;
            got.arc_value = rsp_arc_value;
            got.arc_index = rsp_arc_index;
            got.consumed_bytes = rsp_consumed_bytes;
            got.error_code = rsp_error_code;
            got.last_of_run = rsp_last_of_run;
            if (expected_words.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "got kind %0d arc %0d idx %0d bytes %0d err %0d last %0b, %s",
                     got.kind, got.arc_value, got.arc_index, got.consumed_bytes,
                     got.error_code, got.last_of_run,
                     $sformatf("wanted kind %0d arc %0d idx %0d bytes %0d err %0d last %0b",
                        want.kind, want.arc_value, want.arc_index, want.consumed_bytes,
                        want.error_code, want.last_of_run)));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_length();
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      // Wrong tag on the last byte re-arms at once; a wrong tag mid-buffer drains.
      add_byte(8'h05, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h00, 1'b1);
      // Buffer ending on the tag itself.
      add_byte(TAG_OID, 1'b1);
      // Indefinite length, then more length octets than allowed.
      add_byte(TAG_OID, 1'b0);
      add_byte(LONG_FORM, 1'b1);
      add_byte(TAG_OID, 1'b0);
      add_byte(LONG_FORM | 8'h09, 1'b1);
      // Zero length in short form.
      add_byte(TAG_OID, 1'b0);
      add_byte(8'h00, 1'b1);
      // A plain identifier with a two-byte subidentifier.
      add_byte(TAG_OID, 1'b0);
      add_byte(8'h03, 1'b0);
      add_byte(8'h2A, 1'b0);
      add_byte(8'h86, 1'b0);
      add_byte(8'h48, 1'b1);
      // Long-form length and a first subidentifier that falls under the third root.
      add_byte(TAG_OID, 1'b0);
      add_byte(LONG_FORM | 8'h01, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h7F, 1'b1);
      // Subidentifier left open at the end of the content.
      add_byte(TAG_OID, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h81, 1'b0);
      add_byte(8'h81, 1'b1);
      // Early end on a byte that also completes two arcs.
      add_byte(TAG_OID, 1'b0);
      add_byte(8'h05, 1'b0);
      add_byte(8'h27, 1'b1);
      while (byte_queue.size() < STIMULUS_WORDS) queue_random_buffer();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (byte_queue.size() > 0 || req_valid || expected_words.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() > 0)
         report_mismatch("expected result words never arrived");
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
